// ===== rtl/core/vpdp_pkg.sv =====
// ----------------------------------------------------------------------------
// vpdp_pkg
// Shared types and constants of the VP8/VP9 RTP descriptor parser.
// ----------------------------------------------------------------------------
package vpdp_pkg;

  typedef enum logic [16:0] {
    PH_FIRST   = 17'h00001,
    PH_PAYLOAD = 17'h00002,
    V8_EXT     = 17'h00004,
    V8_PID1    = 17'h00008,
    V8_PID2    = 17'h00010,
    V8_TL0     = 17'h00020,
    V8_TK      = 17'h00040,
    V9_PID1    = 17'h00080,
    V9_PID2    = 17'h00100,
    V9_LAYER   = 17'h00200,
    V9_TL0     = 17'h00400,
    V9_REF     = 17'h00800,
    V9_SS      = 17'h01000,
    V9_SIZE    = 17'h02000,
    V9_NG      = 17'h04000,
    V9_PG      = 17'h08000,
    V9_PDIFF   = 17'h10000
  } phase_e;

  typedef struct packed {
    logic sync;
    logic size;
    logic key;
    logic vp9;
  } status_t;

  // per-word summary handed down the pipeline
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_payload;
    logic        done;
    logic [7:0]  desc_len;
    logic        key_frame;
    logic        size_valid;
    logic [15:0] width;
    logic [15:0] height;
    logic [1:0]  wscale;
    logic [1:0]  hscale;
    logic        incomplete;
  } sum_t;

  // VP8 payload header byte offsets
  localparam logic [3:0] OFS_KEY   = 4'd0;
  localparam logic [3:0] OFS_SYNC0 = 4'd3;
  localparam logic [3:0] OFS_SYNC1 = 4'd4;
  localparam logic [3:0] OFS_SYNC2 = 4'd5;
  localparam logic [3:0] OFS_W_LO  = 4'd6;
  localparam logic [3:0] OFS_W_HI  = 4'd7;
  localparam logic [3:0] OFS_H_LO  = 4'd8;
  localparam logic [3:0] OFS_H_HI  = 4'd9;
  localparam logic [3:0] OFS_SAT   = 4'd10;

  localparam logic [7:0] SYNC_B0 = 8'h9d;
  localparam logic [7:0] SYNC_B1 = 8'h01;
  localparam logic [7:0] SYNC_B2 = 8'h2a;

  localparam logic [2:0] SIZE_BYTES = 3'd4;

endpackage

// ===== rtl/core/vpdp_parse.sv =====
// ----------------------------------------------------------------------------
// vpdp_parse
// Descriptor walk, one byte per word, with the packet summary registered.
// ----------------------------------------------------------------------------
module vpdp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           codec_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_first_i,
  input  logic           in_last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vpdp_pkg::sum_t out_o
);
  import vpdp_pkg::*;

  function automatic phase_e v8_after_tl0(input logic [7:0] f);
    return (f[5:4] != 2'b00) ? V8_TK : PH_PAYLOAD;
  endfunction

  function automatic phase_e v8_after_pid(input logic [7:0] f);
    return f[6] ? V8_TL0 : v8_after_tl0(f);
  endfunction

  function automatic phase_e v9_after_sizes(input logic [7:0] f);
    return f[0] ? V9_NG : PH_PAYLOAD;
  endfunction

  function automatic phase_e v9_after_ref(input logic [7:0] f);
    return f[1] ? V9_SS : PH_PAYLOAD;
  endfunction

  function automatic phase_e v9_after_layer(input logic [7:0] f);
    return (f[6] && f[4]) ? V9_REF : v9_after_ref(f);
  endfunction

  function automatic phase_e v9_after_pid(input logic [7:0] f);
    return f[5] ? V9_LAYER : v9_after_layer(f);
  endfunction

  phase_e      phase_q, phase_d, cur_phase, nxt_phase;
  logic [7:0]  flags_q, flags_d, cur_flags, nxt_flags;
  logic [2:0]  skip_q, skip_d, cur_skip, nxt_skip;
  logic [3:0]  layers_q, layers_d, cur_layers, nxt_layers;
  logic [7:0]  groups_q, groups_d, cur_groups, nxt_groups;
  logic [3:0]  ofs_q, ofs_d, cur_ofs, nxt_ofs;
  logic [7:0]  hcnt_q, hcnt_d, cur_hcnt, nxt_hcnt;
  logic [15:0] cap_w_q, cap_w_d, cur_cap_w, nxt_cap_w;
  logic [15:0] cap_h_q, cap_h_d, cur_cap_h, nxt_cap_h;
  logic [31:0] cap_area_q, cap_area_d, cur_area, nxt_area;
  logic [23:0] lw_q, nxt_lw;
  status_t     st_q, st_d, cur_st, nxt_st;
  logic        v_q, v_d;
  sum_t        sum_q, sum_d;
  logic        acc, is_pay;
  logic [15:0] lay_w, lay_h;
  logic [31:0] lay_area;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = !v_q || out_ready_i;

  assign lay_w    = lw_q[23:8];
  assign lay_h    = {lw_q[7:0], in_byte_i};
  assign lay_area = lay_w * lay_h;

  always_comb begin
    cur_phase  = in_first_i ? PH_FIRST : phase_q;
    cur_flags  = in_first_i ? 8'h00 : flags_q;
    cur_skip   = in_first_i ? 3'd0 : skip_q;
    cur_layers = in_first_i ? 4'd0 : layers_q;
    cur_groups = in_first_i ? 8'h00 : groups_q;
    cur_ofs    = in_first_i ? 4'd0 : ofs_q;
    cur_hcnt   = in_first_i ? 8'h00 : hcnt_q;
    cur_cap_w  = in_first_i ? 16'h0000 : cap_w_q;
    cur_cap_h  = in_first_i ? 16'h0000 : cap_h_q;
    cur_area   = in_first_i ? 32'h0 : cap_area_q;
    cur_st     = in_first_i ? status_t'('0) : st_q;

    nxt_phase  = cur_phase;
    nxt_flags  = cur_flags;
    nxt_skip   = cur_skip;
    nxt_layers = cur_layers;
    nxt_groups = cur_groups;
    nxt_ofs    = cur_ofs;
    nxt_hcnt   = cur_hcnt;
    nxt_cap_w  = cur_cap_w;
    nxt_cap_h  = cur_cap_h;
    nxt_area   = cur_area;
    nxt_st     = cur_st;
    nxt_lw     = lw_q;

    is_pay = (cur_phase == PH_PAYLOAD);

    if (is_pay) begin
      if (!cur_st.vp9) begin
        if (cur_flags[0]) begin
          unique case (cur_ofs)
            OFS_KEY:   if (!in_byte_i[0]) nxt_st.key = 1'b1;
            OFS_SYNC0: if (in_byte_i == SYNC_B0) nxt_st.sync = 1'b1;
            OFS_SYNC1: if (in_byte_i != SYNC_B1) nxt_st.sync = 1'b0;
            OFS_SYNC2: if (in_byte_i != SYNC_B2) nxt_st.sync = 1'b0;
            OFS_W_LO:  nxt_cap_w = {8'h00, in_byte_i};
            OFS_W_HI:  nxt_cap_w = {cur_cap_w[15:8] | in_byte_i, cur_cap_w[7:0]};
            OFS_H_LO:  nxt_cap_h = {8'h00, in_byte_i};
            OFS_H_HI: begin
              nxt_cap_h = {cur_cap_h[15:8] | in_byte_i, cur_cap_h[7:0]};
              if (cur_st.key && cur_st.sync) nxt_st.size = 1'b1;
            end
            default: ;
          endcase
        end
        if (cur_ofs < OFS_SAT) nxt_ofs = cur_ofs + 4'd1;
      end
    end else begin
      if (cur_hcnt != 8'hFF) nxt_hcnt = cur_hcnt + 8'd1;
      unique case (cur_phase)
        PH_FIRST: begin
          if (codec_i) begin
            nxt_st.vp9 = 1'b1;
            nxt_flags  = in_byte_i & 8'hFE;
            nxt_phase  = in_byte_i[7] ? V9_PID1 : v9_after_pid(nxt_flags);
          end else begin
            nxt_flags = {7'b0, in_byte_i[4]};
            nxt_phase = in_byte_i[7] ? V8_EXT : PH_PAYLOAD;
          end
        end
        V8_EXT: begin
          nxt_flags = {in_byte_i[7:4], 3'b000, cur_flags[0]};
          nxt_phase = in_byte_i[7] ? V8_PID1 : v8_after_pid(nxt_flags);
        end
        V8_PID1:  nxt_phase = in_byte_i[7] ? V8_PID2 : v8_after_pid(cur_flags);
        V8_PID2:  nxt_phase = v8_after_pid(cur_flags);
        V8_TL0:   nxt_phase = v8_after_tl0(cur_flags);
        V8_TK:    nxt_phase = PH_PAYLOAD;
        V9_PID1:  nxt_phase = in_byte_i[7] ? V9_PID2 : v9_after_pid(cur_flags);
        V9_PID2:  nxt_phase = v9_after_pid(cur_flags);
        V9_LAYER: nxt_phase = cur_flags[4] ? v9_after_layer(cur_flags) : V9_TL0;
        V9_TL0:   nxt_phase = v9_after_layer(cur_flags);
        V9_REF:   nxt_phase = in_byte_i[0] ? V9_REF : v9_after_ref(cur_flags);
        V9_SS: begin
          if (in_byte_i[3]) nxt_flags[0] = 1'b1;
          if (in_byte_i[4]) begin
            nxt_st.key = 1'b1;
            nxt_layers = {1'b0, in_byte_i[7:5]} + 4'd1;
            nxt_skip   = SIZE_BYTES;
            nxt_phase  = V9_SIZE;
          end else begin
            nxt_phase = v9_after_sizes(nxt_flags);
          end
        end
        V9_SIZE: begin
          nxt_lw   = {lw_q[15:0], in_byte_i};
          nxt_skip = cur_skip - 3'd1;
          if (nxt_skip == 3'd0) begin
            if (lay_area > cur_area) begin
              nxt_cap_w = lay_w;
              nxt_cap_h = lay_h;
              nxt_area  = lay_area;
            end
            nxt_layers = cur_layers - 4'd1;
            if (nxt_layers == 4'd0) begin
              nxt_st.size = 1'b1;
              nxt_phase   = v9_after_sizes(cur_flags);
            end else begin
              nxt_skip = SIZE_BYTES;
            end
          end
        end
        V9_NG: begin
          nxt_groups = in_byte_i;
          nxt_phase  = (in_byte_i != 8'h00) ? V9_PG : PH_PAYLOAD;
        end
        V9_PG: begin
          nxt_skip = {1'b0, in_byte_i[3:2]};
          if (nxt_skip != 3'd0) begin
            nxt_phase = V9_PDIFF;
          end else begin
            nxt_groups = cur_groups - 8'd1;
            nxt_phase  = (nxt_groups != 8'h00) ? V9_PG : PH_PAYLOAD;
          end
        end
        V9_PDIFF: begin
          nxt_skip = cur_skip - 3'd1;
          if (nxt_skip == 3'd0) begin
            nxt_groups = cur_groups - 8'd1;
            nxt_phase  = (nxt_groups != 8'h00) ? V9_PG : PH_PAYLOAD;
          end
        end
        default: nxt_phase = PH_PAYLOAD;
      endcase
    end

    sum_d            = '0;
    sum_d.out_byte   = in_byte_i;
    sum_d.is_payload = is_pay;
    sum_d.done       = in_last_i;
    if (in_last_i) begin
      sum_d.desc_len   = nxt_hcnt;
      sum_d.key_frame  = nxt_st.key;
      sum_d.size_valid = nxt_st.size;
      sum_d.incomplete = (nxt_phase != PH_PAYLOAD);
      if (nxt_st.size) begin
        if (nxt_st.vp9) begin
          sum_d.width  = nxt_cap_w;
          sum_d.height = nxt_cap_h;
        end else begin
          sum_d.width  = {2'b00, nxt_cap_w[13:0]};
          sum_d.height = {2'b00, nxt_cap_h[13:0]};
          sum_d.wscale = nxt_cap_w[15:14];
          sum_d.hscale = nxt_cap_h[15:14];
        end
      end
    end

    if (in_last_i) begin
      phase_d    = PH_FIRST;
      flags_d    = 8'h00;
      skip_d     = 3'd0;
      layers_d   = 4'd0;
      groups_d   = 8'h00;
      ofs_d      = 4'd0;
      hcnt_d     = 8'h00;
      cap_w_d    = 16'h0000;
      cap_h_d    = 16'h0000;
      cap_area_d = 32'h0;
      st_d       = '0;
    end else begin
      phase_d    = nxt_phase;
      flags_d    = nxt_flags;
      skip_d     = nxt_skip;
      layers_d   = nxt_layers;
      groups_d   = nxt_groups;
      ofs_d      = nxt_ofs;
      hcnt_d     = nxt_hcnt;
      cap_w_d    = nxt_cap_w;
      cap_h_d    = nxt_cap_h;
      cap_area_d = nxt_area;
      st_d       = nxt_st;
    end

    v_d = acc ? 1'b1 : (out_ready_i ? 1'b0 : v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      flags_q    <= 8'h00;
      skip_q     <= 3'd0;
      layers_q   <= 4'd0;
      groups_q   <= 8'h00;
      ofs_q      <= 4'd0;
      hcnt_q     <= 8'h00;
      cap_w_q    <= 16'h0000;
      cap_h_q    <= 16'h0000;
      cap_area_q <= 32'h0;
      st_q       <= '0;
      v_q        <= 1'b0;
    end else begin
      v_q <= v_d;
      if (acc) begin
        phase_q    <= phase_d;
        flags_q    <= flags_d;
        skip_q     <= skip_d;
        layers_q   <= layers_d;
        groups_q   <= groups_d;
        ofs_q      <= ofs_d;
        hcnt_q     <= hcnt_d;
        cap_w_q    <= cap_w_d;
        cap_h_q    <= cap_h_d;
        cap_area_q <= cap_area_d;
        st_q       <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      lw_q  <= nxt_lw;
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = sum_q;

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_last_i |=> phase_q == PH_FIRST && hcnt_q == 8'h00 && st_q == '0)
    else $error("packet state not cleared after last word");

  a_summary_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.done |-> out_o.desc_len == 8'h00 && !out_o.size_valid
                                   && !out_o.incomplete && !out_o.key_frame)
    else $error("summary fields set on a word that is not last");

  a_size_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.size_valid |-> out_o.width == 16'h0000
                                         && out_o.height == 16'h0000)
    else $error("size reported without size_valid");

endmodule

// ===== rtl/core/vpdp_area.sv =====
// ----------------------------------------------------------------------------
// vpdp_area
// Pipeline stage that multiplies the packet width by height.
// ----------------------------------------------------------------------------
module vpdp_area (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vpdp_pkg::sum_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vpdp_pkg::sum_t out_o,
  output logic [31:0]    area_o
);
  import vpdp_pkg::*;

  logic        v_q;
  logic        acc;
  sum_t        sum_q;
  logic [31:0] area_q, area_d;

  assign in_ready_o = !v_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign area_d     = in_i.width * in_i.height;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (acc) begin
      v_q <= 1'b1;
    end else if (out_ready_i) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sum_q  <= in_i;
      area_q <= area_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = sum_q;
  assign area_o      = area_q;

endmodule

// ===== rtl/core/vpdp_best.sv =====
// ----------------------------------------------------------------------------
// vpdp_best
// Largest-area resolution tracker and output register.
// ----------------------------------------------------------------------------
module vpdp_best (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vpdp_pkg::sum_t in_i,
  input  logic [31:0]    area_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vpdp_pkg::sum_t out_o,
  output logic [15:0]    best_width_o
);
  import vpdp_pkg::*;

  logic        v_q;
  logic        acc, upd;
  sum_t        sum_q;
  logic [15:0] best_w_q, best_w_d;
  logic [31:0] best_area_q, best_area_d;
  logic [15:0] bw_q;

  assign in_ready_o = !v_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign upd        = in_i.done && in_i.size_valid && (area_i > best_area_q);
  assign best_w_d    = upd ? in_i.width : best_w_q;
  assign best_area_d = upd ? area_i : best_area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= 1'b0;
      best_w_q    <= 16'h0000;
      best_area_q <= 32'h0;
    end else begin
      if (acc) begin
        v_q         <= 1'b1;
        best_w_q    <= best_w_d;
        best_area_q <= best_area_d;
      end else if (out_ready_i) begin
        v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sum_q <= in_i;
      bw_q  <= best_w_d;
    end
  end

  assign out_valid_o  = v_q;
  assign out_o        = sum_q;
  assign best_width_o = bw_q;

  a_area_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_area_q >= $past(best_area_q))
    else $error("best area decreased");

  a_width_tracks_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_area_q == 32'h0) == (best_w_q == 16'h0000))
    else $error("best width and area disagree");

endmodule

// ===== rtl/core/vp8_vp9_rtp_descriptor_parser_core.sv =====
// ----------------------------------------------------------------------------
// vp8_vp9_rtp_descriptor_parser_core
// VP8/VP9 RTP payload descriptor parser with packet summary and best size.
// ----------------------------------------------------------------------------
// Input words pass through the registered parse, multiply and best stages in order.
// Throughput: one word per cycle; stalls only on output backpressure.
// Reset: parse restarts at the first descriptor octet, codec select is VP8,
// best resolution is zero. No clearing pass.
module vp8_vp9_rtp_descriptor_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // codec_select
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i, // data_byte
  input  logic        s_axis_tuser_i, // first_byte
  input  logic        s_axis_tlast_i, // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_byte, descriptor_length, key_frame, size_valid, packet_width,
  // packet_height, width_scale, height_scale, best_width, header_incomplete
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o, // is_payload
  output logic        m_axis_tlast_o  // packet_done
);
  import vpdp_pkg::*;

  logic        codec_q;
  logic        p_valid, p_ready, a_valid, a_ready;
  sum_t        p_sum, a_sum, o_sum;
  logic [31:0] a_area;
  logic [15:0] best_width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_q <= 1'b0;
    end else if (cfg_we_i) begin
      codec_q <= cfg_wdata_i;
    end
  end

  vpdp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .codec_i     (codec_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_first_i  (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_o       (p_sum)
  );

  vpdp_area u_area (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .in_i        (p_sum),
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_o       (a_sum),
    .area_o      (a_area)
  );

  vpdp_best u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (a_valid),
    .in_ready_o   (a_ready),
    .in_i         (a_sum),
    .area_i       (a_area),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (o_sum),
    .best_width_o (best_width)
  );

  assign m_axis_tdata_o = {1'b0, o_sum.incomplete, best_width, o_sum.hscale, o_sum.wscale,
                           o_sum.height, o_sum.width, o_sum.size_valid, o_sum.key_frame,
                           o_sum.desc_len, o_sum.out_byte};
  assign m_axis_tuser_o = o_sum.is_payload;
  assign m_axis_tlast_o = o_sum.done;

endmodule
